/* hdl/idst_pkg.sv */
package idst_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 64;
    localparam int DATA_WIDTH  = 64;

    // Fixed field widths of the ports.
    localparam int ACTION_W = 3;
    localparam int ID_W     = 32;
    localparam int REC_W    = 64;
    localparam int SLOT_W   = 6;
    localparam int EIU_W    = 7;
    localparam logic [EIU_W-1:0] EIU_RESET = 7'd64;

    // Derived widths: slot address and slot count (the count can hold TABLE_DEPTH).
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // Command codes.
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_MODIFY = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_FIND   = 3'd4;

    // Status codes.
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    // Requests from the command sequencer to the table storage.
    typedef struct packed {
        logic [IDX_W-1:0]      rd_addr;
        logic                  wr_en;
        logic [IDX_W-1:0]      wr_addr;
        logic [ID_W-1:0]       wr_id;
        logic [DATA_WIDTH-1:0] wr_data;
        logic                  set_valid;
        logic                  clr_valid;
        logic                  clear_all;
        logic [CNT_W-1:0]      clear_count;
    } idst_req_t;

    // Registered read response from the table storage.
    typedef struct packed {
        logic            rd_valid;
        logic [ID_W-1:0] rd_id;
    } idst_rsp_t;

endpackage

/* hdl/idst_table.sv */
module idst_table (
    input  logic                clk,
    input  logic                rst_n,
    input  idst_pkg::idst_req_t req,
    output idst_pkg::idst_rsp_t rsp
);
    import idst_pkg::*;

    // Valid marks live in flip-flops so that reset and clear act at once.
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [TABLE_DEPTH-1:0] valid_next;

    // Identifier and data word of each slot, one memory word per slot.
    logic [ID_W+DATA_WIDTH-1:0] entry_mem [TABLE_DEPTH];

    logic            rd_valid_reg;
    logic [ID_W-1:0] rd_id_reg;

    // Next valid marks: clear the slots in use, or set or drop one slot.
    always_comb
    begin
        valid_next = valid_reg;
        if (req.clear_all)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                if (CNT_W'(i) < req.clear_count)
                begin
                    valid_next[i] = 1'b0;
                end
            end
        end
        else if (req.set_valid)
        begin
            valid_next[req.wr_addr] = 1'b1;
        end
        else if (req.clr_valid)
        begin
            valid_next[req.wr_addr] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Synchronous memory; the identifier and valid mark of the read slot are registered.
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            entry_mem[req.wr_addr] <= {req.wr_id, req.wr_data};
        end
        rd_id_reg    <= entry_mem[req.rd_addr][ID_W+DATA_WIDTH-1 -: ID_W];
        rd_valid_reg <= valid_reg[req.rd_addr];
    end

    assign rsp.rd_valid = rd_valid_reg;
    assign rsp.rd_id    = rd_id_reg;

endmodule

/* hdl/id_tagged_slot_table.sv */
// Channel   Handshake                 Payload
// in        in_valid / in_ready       action, entry_id, record_data
// out       out_valid / out_ready     status, slot_index, assigned_id
// cfg       cfg_wr_en                 cfg_wr_data (entries_in_use)
//
// Clear, unknown commands and commands with no slots in use skip the scan.
// Insert, remove, modify and find scan the slots in use one per cycle through
// the table memory port until a hit or the last slot in use, then finish.
// Reset empties every slot at once; no clearing pass is needed.
// in_ready is high only in idle; a finished result waits in the output
// register while the next transaction is taken and scanned.
module id_tagged_slot_table (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [idst_pkg::ACTION_W-1:0] action,
    input  logic [idst_pkg::ID_W-1:0]     entry_id,
    input  logic [idst_pkg::REC_W-1:0]    record_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          status,
    output logic [idst_pkg::SLOT_W-1:0]   slot_index,
    output logic [idst_pkg::ID_W-1:0]     assigned_id,
    input  logic                          cfg_wr_en,
    input  logic [idst_pkg::EIU_W-1:0]    cfg_wr_data
);
    import idst_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    // Control registers.
    logic [1:0]       st_reg,        st_next;
    logic [EIU_W-1:0] eiu_reg,       eiu_next;
    logic             p_vld_reg,     p_vld_next;
    logic             out_valid_reg, out_valid_next;
    logic [ID_W-1:0]  next_id_reg,   next_id_next;

    // Command and result payload registers.
    logic [ACTION_W-1:0]   cmd_act_reg,  cmd_act_next;
    logic [ID_W-1:0]       cmd_id_reg,   cmd_id_next;
    logic [DATA_WIDTH-1:0] cmd_data_reg, cmd_data_next;
    logic [CNT_W-1:0]      n_reg,        n_next;
    logic [IDX_W-1:0]      addr_reg,     addr_next;
    logic [IDX_W-1:0]      p_idx_reg,    p_idx_next;
    logic                  p_last_reg,   p_last_next;
    logic                  res_fail_reg, res_fail_next;
    logic [IDX_W-1:0]      res_idx_reg,  res_idx_next;
    logic [ID_W-1:0]       res_aid_reg,  res_aid_next;
    logic                  status_reg,   status_next;
    logic [SLOT_W-1:0]     slot_index_reg, slot_index_next;
    logic [ID_W-1:0]       assigned_id_reg, assigned_id_next;

    idst_req_t req;
    idst_rsp_t rsp;

    logic             accept;
    logic [CNT_W-1:0] active_n;
    logic             is_insert;
    logic             hit;
    logic             scan_end;
    logic             out_free;
    logic [ID_W-1:0]  id_inc;

    idst_table u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Handshake and slot count in use, saturated to the table depth.
    assign in_ready = (st_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign id_inc   = next_id_reg + ID_W'(1);

    always_comb
    begin
        if (32'(eiu_reg) > 32'(TABLE_DEPTH))
        begin
            active_n = CNT_W'(TABLE_DEPTH);
        end
        else
        begin
            active_n = CNT_W'(eiu_reg);
        end
    end

    // Match check on the slot read in the previous cycle.
    assign is_insert = (cmd_act_reg == ACT_INSERT);
    assign hit       = p_vld_reg && (is_insert ? !rsp.rd_valid
                                               : (rsp.rd_valid && rsp.rd_id == cmd_id_reg));
    assign scan_end  = (st_reg == S_SCAN) && p_vld_reg && (hit || p_last_reg);

    // Requests to the table: read the scan address, write back on an insert or modify hit.
    always_comb
    begin
        req.rd_addr     = addr_reg;
        req.wr_en       = scan_end && hit
                          && (is_insert || cmd_act_reg == ACT_MODIFY);
        req.wr_addr     = p_idx_reg;
        req.wr_id       = is_insert ? id_inc : rsp.rd_id;
        req.wr_data     = cmd_data_reg;
        req.set_valid   = scan_end && hit && is_insert;
        req.clr_valid   = scan_end && hit && (cmd_act_reg == ACT_REMOVE);
        req.clear_all   = accept && (action == ACT_CLEAR) && (active_n != '0);
        req.clear_count = active_n;
    end

    // Command sequencer.
    always_comb
    begin
        st_next          = st_reg;
        eiu_next         = cfg_wr_en ? cfg_wr_data : eiu_reg;
        p_vld_next       = 1'b0;
        next_id_next     = next_id_reg;
        cmd_act_next     = cmd_act_reg;
        cmd_id_next      = cmd_id_reg;
        cmd_data_next    = cmd_data_reg;
        n_next           = n_reg;
        addr_next        = addr_reg;
        p_idx_next       = p_idx_reg;
        p_last_next      = p_last_reg;
        res_fail_next    = res_fail_reg;
        res_idx_next     = res_idx_reg;
        res_aid_next     = res_aid_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        status_next      = status_reg;
        slot_index_next  = slot_index_reg;
        assigned_id_next = assigned_id_reg;

        unique case (st_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_act_next  = action;
                    cmd_id_next   = entry_id;
                    cmd_data_next = record_data[DATA_WIDTH-1:0];
                    n_next        = active_n;
                    addr_next     = '0;
                    res_idx_next  = '0;
                    res_aid_next  = '0;
                    priority if (active_n == '0 || action > ACT_FIND)
                    begin
                        res_fail_next = STATUS_FAIL;
                        st_next       = S_FINISH;
                    end
                    else if (action == ACT_CLEAR)
                    begin
                        res_fail_next = STATUS_OK;
                        st_next       = S_FINISH;
                    end
                    else
                    begin
                        st_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_end)
                begin
                    st_next = S_FINISH;
                    if (hit)
                    begin
                        res_fail_next = STATUS_OK;
                        res_idx_next  = p_idx_reg;
                        if (is_insert)
                        begin
                            res_aid_next = id_inc;
                            next_id_next = id_inc;
                        end
                        else
                        begin
                            res_aid_next = cmd_id_reg;
                        end
                    end
                    else
                    begin
                        res_fail_next = STATUS_FAIL;
                        res_idx_next  = '0;
                        res_aid_next  = '0;
                    end
                end
                else
                begin
                    // Issue the read of the next slot in use.
                    p_vld_next  = 1'b1;
                    p_idx_next  = addr_reg;
                    p_last_next = (CNT_W'(addr_reg) + CNT_W'(1)) == n_reg;
                    addr_next   = addr_reg + IDX_W'(1);
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    status_next      = res_fail_reg;
                    slot_index_next  = SLOT_W'(res_idx_reg);
                    assigned_id_next = res_aid_reg;
                    st_next          = S_IDLE;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= S_IDLE;
            eiu_reg       <= EIU_RESET;
            p_vld_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            next_id_reg   <= '0;
        end
        else
        begin
            st_reg        <= st_next;
            eiu_reg       <= eiu_next;
            p_vld_reg     <= p_vld_next;
            out_valid_reg <= out_valid_next;
            next_id_reg   <= next_id_next;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        cmd_act_reg     <= cmd_act_next;
        cmd_id_reg      <= cmd_id_next;
        cmd_data_reg    <= cmd_data_next;
        n_reg           <= n_next;
        addr_reg        <= addr_next;
        p_idx_reg       <= p_idx_next;
        p_last_reg      <= p_last_next;
        res_fail_reg    <= res_fail_next;
        res_idx_reg     <= res_idx_next;
        res_aid_reg     <= res_aid_next;
        status_reg      <= status_next;
        slot_index_reg  <= slot_index_next;
        assigned_id_reg <= assigned_id_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign slot_index  = slot_index_reg;
    assign assigned_id = assigned_id_reg;

endmodule

/* hdl/idst_checker.sv */
module idst_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic                          status,
    input logic [idst_pkg::SLOT_W-1:0]   slot_index,
    input logic [idst_pkg::ID_W-1:0]     assigned_id
);
    import idst_pkg::*;

    // The block works on one transaction at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("input taken while a command was still in progress");

    // A failed result carries neither a slot nor an identifier.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_FAIL |-> slot_index == '0 && assigned_id == '0)
    else $error("failed result with nonzero slot or identifier");

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(slot_index) && $stable(assigned_id))
    else $error("result changed or dropped while stalled");

endmodule

bind id_tagged_slot_table idst_checker u_idst_checker (.*);
